### src/mwa_pkg.sv
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared types, constants and arithmetic helpers of the whitening block.
// ----------------------------------------------------------------------------
package mwa_pkg;

    // Default parameter values.
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int COEF_BITS_DEF    = 24;

    // Fixed field widths.
    localparam int IDX_W      = 6;
    localparam int OUT_BITS   = 24;
    localparam int ACC_W      = 64;
    localparam int CNT_W      = 7;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHIFT     = 1'b1;

    // Request types.
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST = 7'd16;
    localparam logic [SHIFT_W-1:0] OUT_SHIFT_RST     = 6'd16;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam longint OUT_MAX_L = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint OUT_MIN_L = -OUT_MAX_L - 1;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Tag that travels with each coefficient read through the MAC pipeline.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] row;
        logic             first;
        logic             last_col;
        logic             last_row;
    } t_tag;

    // Signed add that clamps to the accumulator range instead of wrapping.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

### src/mwa_in_if.sv
// ----------------------------------------------------------------------------
// mwa_in_if
// Input channel: coefficient loads and channel samples.
// ----------------------------------------------------------------------------
interface mwa_in_if #(
    parameter int SAMPLE_BITS = mwa_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = mwa_pkg::COEF_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [mwa_pkg::IDX_W-1:0]         row_index;
    logic [mwa_pkg::IDX_W-1:0]         channel_index;
    logic signed [COEF_BITS-1:0]       coef_value;
    logic signed [SAMPLE_BITS-1:0]     sample_value;

    modport source (
        output valid, req_type, row_index, channel_index, coef_value, sample_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, row_index, channel_index, coef_value, sample_value,
        output ready
    );
endinterface

### src/mwa_out_if.sv
// ----------------------------------------------------------------------------
// mwa_out_if
// Output channel: one whitened value per output channel.
// ----------------------------------------------------------------------------
interface mwa_out_if;
    logic                                valid;
    logic                                ready;
    logic [mwa_pkg::IDX_W-1:0]           out_channel;
    logic signed [mwa_pkg::OUT_BITS-1:0] out_value;
    logic                                out_last;

    modport source (
        output valid, out_channel, out_value, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_channel, out_value, out_last,
        output ready
    );
endinterface

### src/multichannel_whitening_apply_top.sv
// ----------------------------------------------------------------------------
// multichannel_whitening_apply_top
// Applies a stored square whitening matrix to each multichannel timepoint.
// ----------------------------------------------------------------------------
// Usage. The input channel carries two kinds of item: a coefficient load writes
// one matrix entry, a sample item writes one channel value of the current
// timepoint. Both are taken one per cycle while the block is idle. The sample
// for the last configured channel starts the matrix-vector product; the output
// channel then delivers channel_count items, one per matrix row, in row order,
// with out_last on the final row.
// A single multiply-accumulate unit reads one coefficient and one sample from
// the memories per cycle unless the pipeline is frozen, and the input is held
// off until the last matrix entry has been read. Each row sum passes through the
// memory read, product, accumulator and result registers before it is output.
// When the receiver stalls, a finished row sum waits behind the result register
// and the whole read and accumulate pipeline freezes until it can move on.
// Reset puts the sequencer and pipeline idle and sets channel_count and
// out_shift to 16; the memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module multichannel_whitening_apply_top #(
    parameter int MAX_CHANNELS = mwa_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mwa_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = mwa_pkg::COEF_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mwa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mwa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mwa_in_if.sink                             i_in,
    mwa_out_if.source                          o_out
);
    import mwa_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CNT_W-1:0]   r_chan_cnt;
    logic [SHIFT_W-1:0] r_out_shift;
    logic [CNT_W-1:0]   w_last_full;
    logic [CH_W-1:0]    w_last;
    logic               w_accept;
    logic               w_row_ok;
    logic               w_col_ok;
    logic               w_coef_we;
    logic               w_samp_we;
    logic               w_start;
    logic               w_busy;
    logic               w_adv;
    logic [CH_W-1:0]    w_rd_row;
    logic [CH_W-1:0]    w_rd_col;
    t_tag               w_tag;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [SAMPLE_BITS-1:0] w_samp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt  <= CHANNEL_COUNT_RST;
            r_out_shift <= OUT_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL_COUNT: r_chan_cnt  <= i_cfg_data[CNT_W-1:0];
                CFG_OUT_SHIFT:     r_out_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // A channel count of zero behaves as one; anything above the maximum is clamped.
    always_comb begin
        if (r_chan_cnt == '0) begin
            w_last_full = '0;
        end else if (r_chan_cnt > CNT_W'(MAX_CHANNELS)) begin
            w_last_full = CNT_W'(MAX_CHANNELS - 1);
        end else begin
            w_last_full = r_chan_cnt - 1'b1;
        end
    end
    assign w_last = w_last_full[CH_W-1:0];

    assign i_in.ready = !w_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_row_ok   = ({1'b0, i_in.row_index} < CNT_W'(MAX_CHANNELS));
    assign w_col_ok   = ({1'b0, i_in.channel_index} < CNT_W'(MAX_CHANNELS));
    assign w_coef_we  = w_accept && (i_in.req_type == REQ_COEF) && w_row_ok && w_col_ok;
    assign w_samp_we  = w_accept && (i_in.req_type == REQ_SAMPLE) && w_col_ok;
    assign w_start    = w_samp_we && ({1'b0, i_in.channel_index} == w_last_full);

    mwa_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS),
        .CH_W         (CH_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_en     (w_adv),
        .i_rd_row    (w_rd_row),
        .i_rd_col    (w_rd_col),
        .i_coef_we   (w_coef_we),
        .i_coef_row  (i_in.row_index[CH_W-1:0]),
        .i_coef_col  (i_in.channel_index[CH_W-1:0]),
        .i_coef_data (i_in.coef_value),
        .i_samp_we   (w_samp_we),
        .i_samp_col  (i_in.channel_index[CH_W-1:0]),
        .i_samp_data (i_in.sample_value),
        .o_coef      (w_coef),
        .o_samp      (w_samp)
    );

    mwa_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_adv    (w_adv),
        .i_last   (w_last),
        .o_busy   (w_busy),
        .o_rd_row (w_rd_row),
        .o_rd_col (w_rd_col),
        .o_tag    (w_tag)
    );

    mwa_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_coef  (w_coef),
        .i_samp  (w_samp),
        .i_shift (r_out_shift),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

    a_start_locks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_in.ready)
        else $error("input still open after the last channel sample of a timepoint");

endmodule

### src/mwa_store.sv
// ----------------------------------------------------------------------------
// mwa_store
// Coefficient matrix memory and sample vector memory, with registered read outputs.
// ----------------------------------------------------------------------------
module mwa_store #(
    parameter int MAX_CHANNELS = mwa_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mwa_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = mwa_pkg::COEF_BITS_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [CH_W-1:0]               i_rd_row,
    input  logic [CH_W-1:0]               i_rd_col,
    input  logic                          i_coef_we,
    input  logic [CH_W-1:0]               i_coef_row,
    input  logic [CH_W-1:0]               i_coef_col,
    input  logic signed [COEF_BITS-1:0]   i_coef_data,
    input  logic                          i_samp_we,
    input  logic [CH_W-1:0]               i_samp_col,
    input  logic signed [SAMPLE_BITS-1:0] i_samp_data,
    output logic signed [COEF_BITS-1:0]   o_coef,
    output logic signed [SAMPLE_BITS-1:0] o_samp
);
    import mwa_pkg::*;

    localparam int COEF_DEPTH = 1 << (2 * CH_W);
    localparam int SAMP_DEPTH = 1 << CH_W;

    // Row-major, with a row stride of a power of two so the address is a concatenation.
    logic [COEF_BITS-1:0]   r_coef_mem [COEF_DEPTH];
    logic [SAMPLE_BITS-1:0] r_samp_mem [SAMP_DEPTH];
    logic [COEF_BITS-1:0]   r_coef_rd;
    logic [SAMPLE_BITS-1:0] r_samp_rd;

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef_mem[{i_coef_row, i_coef_col}] <= i_coef_data;
        end
        if (i_rd_en) begin
            r_coef_rd <= r_coef_mem[{i_rd_row, i_rd_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_samp_we) begin
            r_samp_mem[i_samp_col] <= i_samp_data;
        end
        if (i_rd_en) begin
            r_samp_rd <= r_samp_mem[i_rd_col];
        end
    end

    assign o_coef = signed'(r_coef_rd);
    assign o_samp = signed'(r_samp_rd);

endmodule

### src/mwa_seq.sv
// ----------------------------------------------------------------------------
// mwa_seq
// Walks the matrix row by row, issuing one coefficient and sample read a cycle while i_adv is high.
// ----------------------------------------------------------------------------
module mwa_seq #(
    parameter int MAX_CHANNELS = mwa_pkg::MAX_CHANNELS_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_adv,
    input  logic [CH_W-1:0]  i_last,
    output logic             o_busy,
    output logic [CH_W-1:0]  o_rd_row,
    output logic [CH_W-1:0]  o_rd_col,
    output mwa_pkg::t_tag    o_tag
);
    import mwa_pkg::*;

    t_seq_state      r_state, n_state;
    logic [CH_W-1:0] r_row, n_row;
    logic [CH_W-1:0] r_col, n_col;
    logic            w_end_col;
    logic            w_end_row;

    assign w_end_col = (r_col == i_last);
    assign w_end_row = (r_row == i_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (i_adv && w_end_col && w_end_row) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (r_state == SEQ_IDLE) begin
            n_row = '0;
            n_col = '0;
        end else if (i_adv) begin
            if (w_end_col) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_comb begin
        o_busy         = (r_state == SEQ_RUN);
        o_rd_row       = r_row;
        o_rd_col       = r_col;
        o_tag.vld      = (r_state == SEQ_RUN);
        o_tag.row      = IDX_W'(r_row);
        o_tag.first    = (r_col == '0);
        o_tag.last_col = w_end_col;
        o_tag.last_row = w_end_row;
    end

    a_last_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN) && i_adv && w_end_col && w_end_row |=> r_state == SEQ_IDLE)
        else $error("sequencer kept running after the final matrix entry");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == SEQ_IDLE)
        else $error("timepoint started while the previous one was still being read");

endmodule

### src/mwa_mac.sv
// ----------------------------------------------------------------------------
// mwa_mac
// Multiply-accumulate pipeline, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module mwa_mac #(
    parameter int SAMPLE_BITS = mwa_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = mwa_pkg::COEF_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mwa_pkg::t_tag                   i_tag,
    input  logic signed [COEF_BITS-1:0]     i_coef,
    input  logic signed [SAMPLE_BITS-1:0]   i_samp,
    input  logic [mwa_pkg::SHIFT_W-1:0]     i_shift,
    output logic                            o_adv,
    mwa_out_if.source                       o_out
);
    import mwa_pkg::*;

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

    t_tag                     r_p1;
    t_tag                     r_p2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_sum;
    logic                     r_sum_vld;
    logic [IDX_W-1:0]         r_sum_row;
    logic                     r_sum_last;
    logic                     r_out_vld;
    logic [IDX_W-1:0]         r_out_ch;
    logic signed [OUT_BITS-1:0] r_out_val;
    logic                     r_out_last;

    logic                     w_take;
    logic                     w_adv;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_bias;
    logic signed [ACC_W-1:0]  w_biased;
    logic signed [ACC_W-1:0]  w_shifted;
    logic signed [OUT_BITS-1:0] w_val;

    // The whole pipeline freezes only when a finished sum cannot move on.
    assign w_take = r_sum_vld && (!r_out_vld || o_out.ready);
    assign w_adv  = !r_sum_vld || w_take;
    assign o_adv  = w_adv;

    assign w_prod = i_coef * i_samp;

    always_comb begin
        w_acc = sat_add(r_p2.first ? '0 : r_acc, ACC_W'(r_prod));
    end

    // Half-up rounding: add half an output step, then shift arithmetically.
    always_comb begin
        w_bias    = {{(ACC_W-1){1'b0}}, 1'b1} << (i_shift - 1'b1);
        w_biased  = (i_shift == '0) ? r_sum : sat_add(r_sum, w_bias);
        w_shifted = w_biased >>> i_shift;
        if (w_shifted > OUT_MAX_L) begin
            w_val = OUT_BITS'(OUT_MAX_L);
        end else if (w_shifted < OUT_MIN_L) begin
            w_val = OUT_BITS'(OUT_MIN_L);
        end else begin
            w_val = w_shifted[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1      <= '0;
            r_p2      <= '0;
            r_sum_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_p1 <= i_tag;
                r_p2 <= r_p1;
            end
            if (w_adv && r_p2.vld && r_p2.last_col) begin
                r_sum_vld <= 1'b1;
            end else if (w_take) begin
                r_sum_vld <= 1'b0;
            end
            if (w_take) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= w_prod;
        end
        if (w_adv && r_p2.vld) begin
            r_acc <= w_acc;
            if (r_p2.last_col) begin
                r_sum      <= w_acc;
                r_sum_row  <= r_p2.row;
                r_sum_last <= r_p2.last_row;
            end
        end
        if (w_take) begin
            r_out_ch   <= r_sum_row;
            r_out_val  <= w_val;
            r_out_last <= r_sum_last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.out_channel = r_out_ch;
    assign o_out.out_value   = r_out_val;
    assign o_out.out_last    = r_out_last;

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_vld && !w_take |=> r_sum_vld && $stable(r_sum))
        else $error("pending row sum lost or changed while the result register was full");

    a_row_end_makes_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_p2.vld && r_p2.last_col |=> r_sum_vld)
        else $error("end of a matrix row did not produce a row sum");

endmodule

### tb/sv/tb_multichannel_whitening_apply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_whitening_apply_top
// Loads whitening matrices and streams multichannel timepoints through the
// block under several channel counts and rounding shifts. A local model of the
// matrix store, the sample vector and the registers predicts every whitened
// value, and each output item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_multichannel_whitening_apply_top;

    import mwa_pkg::*;

    localparam int NCH        = MAX_CHANNELS_DEF;
    localparam int COEF_W     = COEF_BITS_DEF;
    localparam int SMP_W      = SAMPLE_BITS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int SETTLE_CYC = 20;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
    localparam logic signed [SMP_W-1:0]  SMP_MAX  = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0]  SMP_MIN  = 16'sh8000;

    typedef struct {
        logic                     req;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [COEF_W-1:0] coef;
        logic signed [SMP_W-1:0]  smp;
        bit                       hold;   // wait for all results before sending
    } t_wh_item;

    typedef struct {
        logic [IDX_W-1:0]           ch;
        logic signed [OUT_BITS-1:0] val;
        logic                       last;
    } t_wh_result;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mwa_in_if  in_if ();
    mwa_out_if out_if ();

    multichannel_whitening_apply_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    t_wh_item   pending_items [$];
    t_wh_result whitened_q [$];
    int         fail_count = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Predictor state: matrix, sample vector and registers.
    // ------------------------------------------------------------------------
    logic signed [COEF_W-1:0] wm_coef [NCH*NCH];
    logic signed [SMP_W-1:0]  wm_smp [NCH];
    logic [CNT_W-1:0]         wm_cnt = CHANNEL_COUNT_RST;
    logic [SHIFT_W-1:0]       wm_shift = OUT_SHIFT_RST;

    task automatic predict_whitened(input t_wh_item it);
        int         n;
        longint     acc;
        longint     v;
        t_wh_result res;
        if (it.req == REQ_COEF) begin
            wm_coef[int'(it.row) * NCH + int'(it.col)] = it.coef;
            return;
        end
        wm_smp[it.col] = it.smp;
        n = (wm_cnt == 0) ? 1 : ((wm_cnt > NCH) ? NCH : int'(wm_cnt));
        if (int'(it.col) != n - 1) return;
        for (int r = 0; r < n; r++) begin
            // 24 x 16 bit products over at most 64 columns stay well inside 64 bits.
            acc = 0;
            for (int c = 0; c < n; c++) begin
                acc += longint'(wm_coef[r * NCH + c]) * longint'(wm_smp[c]);
            end
            v = acc;
            if (wm_shift != 0) begin
                v = (acc + (longint'(1) <<< (wm_shift - 1))) >>> wm_shift;
            end
            if (v > OUT_MAX_L) v = OUT_MAX_L;
            if (v < OUT_MIN_L) v = OUT_MIN_L;
            res.ch   = r[IDX_W-1:0];
            res.val  = v[OUT_BITS-1:0];
            res.last = (r == n - 1);
            whitened_q.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver and output back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_wh_item cur;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            // A held item also waits out an item being accepted at this edge,
            // whose predictions may not be queued yet.
            if (pending_items.size() != 0 &&
                (!pending_items[0].hold ||
                 (whitened_q.size() == 0 && !(in_if.valid && in_if.ready))) &&
                $urandom_range(0, 99) >= src_idle_pct) begin
                cur = pending_items.pop_front();
                in_if.valid         <= 1'b1;
                in_if.req_type      <= cur.req;
                in_if.row_index     <= cur.row;
                in_if.channel_index <= cur.col;
                in_if.coef_value    <= cur.coef;
                in_if.sample_value  <= cur.smp;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: register writes, accepted items and result checks.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_wh_item   it;
        t_wh_result exp_res;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_CHANNEL_COUNT: wm_cnt = cfg_data[CNT_W-1:0];
                    CFG_OUT_SHIFT:     wm_shift = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                it.req  = in_if.req_type;
                it.row  = in_if.row_index;
                it.col  = in_if.channel_index;
                it.coef = in_if.coef_value;
                it.smp  = in_if.sample_value;
                it.hold = 1'b0;
                predict_whitened(it);
            end
            if (out_if.valid && out_if.ready) begin
                if (whitened_q.size() == 0) begin
                    $display(
                        "%0t: expected no result, got ch %0d value %0d last %0b",
                        $time, out_if.out_channel, out_if.out_value, out_if.out_last);
                    fail_count++;
                end else begin
                    exp_res = whitened_q.pop_front();
                    if (out_if.out_channel !== exp_res.ch ||
                        out_if.out_value !== exp_res.val ||
                        out_if.out_last !== exp_res.last) begin
                        $display(
                            "%0t: expected ch %0d val %0d last %0b, got %0d %0d %0b",
                            $time, exp_res.ch, exp_res.val, exp_res.last,
                            out_if.out_channel, out_if.out_value, out_if.out_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_if.valid && in_if.ready) ||
            (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. The generator tracks which entries have been written so that
    // no timepoint ever reads an uninitialised coefficient or sample.
    // ------------------------------------------------------------------------
    bit               coef_seen [NCH*NCH];
    bit               smp_seen [NCH];
    logic [CNT_W-1:0] gen_cnt = CHANNEL_COUNT_RST;
    bit               gen_hold = 1'b0;
    int               made_items;

    function automatic int active_channels();
        return (gen_cnt == 0) ? 1 : ((gen_cnt > NCH) ? NCH : int'(gen_cnt));
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        int t;
        t = int'($urandom_range(0, 511)) - 256;
        case ($urandom_range(0, 7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2, 3: return t[COEF_W-1:0];
            default: return COEF_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int t;
        t = int'($urandom_range(0, 63)) - 32;
        case ($urandom_range(0, 7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return t[SMP_W-1:0];
            default: return SMP_W'($urandom());
        endcase
    endfunction

    task automatic queue_item(input logic req, input int row, input int col,
                              input logic signed [COEF_W-1:0] coef,
                              input logic signed [SMP_W-1:0] smp);
        t_wh_item it;
        it.req  = req;
        it.row  = row[IDX_W-1:0];
        it.col  = col[IDX_W-1:0];
        it.coef = coef;
        it.smp  = smp;
        it.hold = gen_hold;
        gen_hold = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic push_load(input int row, input int col,
                             input logic signed [COEF_W-1:0] coef);
        coef_seen[row * NCH + col] = 1'b1;
        queue_item(REQ_COEF, row, col, coef, pick_sample());
    endtask

    task automatic push_sample(input int col, input logic signed [SMP_W-1:0] smp);
        int n;
        n = active_channels();
        if (col == n - 1) begin
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    if (!coef_seen[r * NCH + c]) push_load(r, c, pick_coef());
                end
            end
            for (int c = 0; c < n - 1; c++) begin
                if (!smp_seen[c]) begin
                    smp_seen[c] = 1'b1;
                    queue_item(REQ_SAMPLE, $urandom_range(0, NCH - 1), c, pick_coef(),
                               pick_sample());
                end
            end
        end
        smp_seen[col] = 1'b1;
        queue_item(REQ_SAMPLE, $urandom_range(0, NCH - 1), col, pick_coef(), smp);
    endtask

    // One timepoint: the other channels in a rotated order, the last one last.
    task automatic queue_timepoint();
        int n;
        int off;
        n = active_channels();
        off = (n > 1) ? $urandom_range(0, n - 2) : 0;
        for (int k = 0; k < n - 1; k++) push_sample((k + off) % (n - 1), pick_sample());
        push_sample(n - 1, pick_sample());
        made_items += n;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int cnt, input int shift);
        write_reg(CFG_CHANNEL_COUNT, cnt[CFG_DATA_W-1:0]);
        write_reg(CFG_OUT_SHIFT, shift[CFG_DATA_W-1:0]);
        gen_cnt = cnt[CNT_W-1:0];
    endtask

    // Wait for every queued item and every predicted result, then let the
    // pipeline run empty before the registers may change.
    task automatic settle();
        while (pending_items.size() != 0 || in_if.valid || whitened_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic random_phase(input int cnt, input int shift, input int budget);
        int n;
        int sel;
        int k;
        bit held;
        settle();
        set_config(cnt, shift);
        n = active_channels();
        made_items = 0;
        held = 1'b0;
        while (made_items < budget) begin
            // Halfway through, the sender waits for the block to run dry.
            if (!held && made_items >= budget / 2) begin
                gen_hold = 1'b1;
                held = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                queue_timepoint();
            end else if (sel < 75) begin
                k = $urandom_range(1, 4);
                repeat (k) push_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                     pick_coef());
                made_items += k;
            end else if (sel < 88) begin
                push_sample($urandom_range(0, NCH - 1), pick_sample());
                made_items++;
            end else begin
                push_load($urandom_range(0, NCH - 1), $urandom_range(0, NCH - 1),
                          pick_coef());
                made_items++;
            end
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_CHANNEL_COUNT;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.req_type      = REQ_COEF;
        in_if.row_index     = '0;
        in_if.channel_index = '0;
        in_if.coef_value    = '0;
        in_if.sample_value  = '0;
        out_if.ready        = 1'b0;
        src_idle_pct        = 23;
        snk_idle_pct        = 47;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Single channel without rounding: saturation at both ends.
        set_config(1, 0);
        push_load(0, 0, COEF_MAX);
        push_sample(0, SMP_MAX);
        push_sample(0, SMP_MIN);
        push_load(0, 0, COEF_MIN);
        push_sample(0, SMP_MIN);
        // Extreme indexes: a load outside the active matrix and a sample for
        // a channel other than the last give no result.
        push_load(63, 63, COEF_MIN);
        push_sample(63, SMP_MAX);
        push_load(0, 0, -24'sd1);
        push_sample(0, 16'sd5);
        settle();

        // A channel count of zero acts as one; the largest shift.
        set_config(0, 63);
        push_load(0, 0, 24'sd1);
        push_sample(0, SMP_MIN);
        push_load(0, 0, COEF_MAX);
        push_sample(0, SMP_MAX);
        settle();

        // Half-up rounding of positive and negative halves.
        set_config(2, 1);
        push_load(0, 0, 24'sd1);
        push_load(0, 1, 24'sd0);
        push_load(1, 0, 24'sd0);
        push_load(1, 1, -24'sd1);
        push_sample(0, 16'sd3);
        push_sample(1, 16'sd3);
        push_sample(1, -16'sd3);

        random_phase(5, 18, 30);
        random_phase(4, 40, 20);

        settle();
        src_idle_pct = 47;
        snk_idle_pct = 23;
        random_phase(6, 30, 25);
        random_phase(3, 0, 20);

        settle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(8, 22, 15);
        random_phase(2, 63, 15);

        settle();
        if (whitened_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, whitened_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
